FILE: hw/rtl/rdi_pkg.sv
// Shared types and constants for the radial distortion inverse unit.
// Depends on nothing; imported by radial_distortion_inverse_unit.
package rdi_pkg;

    localparam int VAL_W  = 24;
    localparam int TOL_W  = 23;
    localparam int INT_W  = 32;
    localparam int PROD_W = 64;
    localparam int NUM_W  = 56;
    localparam int CFG_W  = 2;

    typedef logic signed [VAL_W-1:0]  t_val;
    typedef logic signed [INT_W-1:0]  t_int;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic [2:0]               t_op;

    localparam t_prod INT_LIM = 64'sd2147483647;
    localparam t_val  VAL_MAX = 24'sh7FFFFF;
    localparam t_val  VAL_MIN = -24'sd8388608;

    localparam logic [CFG_W-1:0] CFG_QUAD = 2'd0;
    localparam logic [CFG_W-1:0] CFG_QUAR = 2'd1;
    localparam logic [CFG_W-1:0] CFG_TOL  = 2'd2;

    localparam t_val             COEF_QUAD_RST = 24'sd576717;
    localparam t_val             COEF_QUAR_RST = 24'sd356516;
    localparam logic [TOL_W-1:0] TOL_RST       = 23'd105;

    localparam t_op OP_SQ  = 3'd0;
    localparam t_op OP_K4  = 3'd1;
    localparam t_op OP_K2  = 3'd2;
    localparam t_op OP_FWD = 3'd3;
    localparam t_op OP_COR = 3'd4;

endpackage

FILE: hw/rtl/radial_distortion_inverse_unit.sv
// Radial distortion inverse: secant search for r with r*(1 + k2*r^2 + k4*r^4) = radius.
// One shared 32x32 multiplier and a one-bit-per-cycle divider under a small sequencer.
// Depends on rdi_pkg. At most MAX_ITER secant steps run, and a zero denominator ends
// the search early; each step takes four multiplies, a correction multiply, a 56-bit
// divide and the bookkeeping states S_CHECK, S_DEN and S_UPD. Reset restores the defaults.
// One request at a time; the next is taken once the result is registered for output.
module radial_distortion_inverse_unit
    import rdi_pkg::*;
#(
    parameter int MAX_ITER  = 16,
    parameter int FRAC_BITS = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_idx,
    input  logic [VAL_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [VAL_W-1:0]     s_axis_tdata,   // [23:0] radius_in
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [VAL_W-1:0]     m_axis_tdata,   // [23:0] radius_out
    output logic                 m_axis_tuser    // [0] not_converged
);

    localparam int SW = $clog2(MAX_ITER + 1);
    localparam int DW = $clog2(NUM_W);
    localparam t_val R_INIT = (FRAC_BITS < VAL_W - 1) ? VAL_W'(1 << FRAC_BITS) : VAL_MAX;
    localparam t_prod ONE_FX = PROD_W'(longint'(1) << FRAC_BITS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_POST  = 3'd3;
    localparam logic [2:0] S_DEN   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_UPD   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    function automatic t_int sat32(input t_prod x);
        t_int y;
        if (x > INT_LIM) begin
            y = INT_LIM[INT_W-1:0];
        end else if (x < -INT_LIM) begin
            y = -INT_LIM[INT_W-1:0];
        end else begin
            y = x[INT_W-1:0];
        end
        return y;
    endfunction

    logic [2:0]       r_state;
    t_op              r_op;
    t_val             r_k2, r_k4;
    logic [TOL_W-1:0] r_tol;
    t_val             r_target, r_r0, r_r1;
    t_int             r_dr0, r_dr1, r_sq;
    t_int             r_ma, r_mb;
    t_prod            r_prod;
    logic [SW-1:0]    r_step;
    logic             r_failed;
    logic [INT_W-1:0] r_dmag;
    logic             r_q_neg;
    logic [NUM_W-1:0] r_num;
    logic [INT_W-1:0] r_rem;
    logic [DW-1:0]    r_dcnt;
    logic             r_out_valid;
    t_val             r_out_r;
    logic             r_out_nc;

    t_prod            mul_p;
    t_prod            resc;
    logic signed [VAL_W:0] diff;
    logic [VAL_W:0]   mag;
    t_int             den;
    t_int             post_a;
    logic [INT_W:0]   rem_sh;
    logic             rem_ge;
    logic [NUM_W+1:0] q_ext;
    logic signed [NUM_W+1:0] corr, nr;
    t_prod            pmag;

    assign mul_p  = PROD_W'(r_ma) * PROD_W'(r_mb);
    assign resc   = r_prod >>> FRAC_BITS;
    assign post_a = sat32(resc);
    assign diff   = (VAL_W+1)'(r_r1) - (VAL_W+1)'(r_r0);
    assign mag    = diff[VAL_W] ? (VAL_W+1)'(-diff) : (VAL_W+1)'(diff);
    assign den    = sat32(PROD_W'(r_dr1) - PROD_W'(r_dr0));
    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_dmag};
    assign q_ext  = {2'b00, r_num};
    assign corr   = r_q_neg ? -$signed(q_ext) : $signed(q_ext);
    assign nr     = (NUM_W+2)'(r_r1) - corr;
    assign pmag   = r_prod[PROD_W-1] ? -r_prod : r_prod;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_r;
    assign m_axis_tuser  = r_out_nc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k2 <= COEF_QUAD_RST;
            r_k4 <= COEF_QUAR_RST;
            r_tol <= TOL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_QUAD: r_k2 <= i_cfg_data;
                CFG_QUAR: r_k4 <= i_cfg_data;
                CFG_TOL:  r_tol <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step <= '0;
            r_failed <= 1'b0;
            r_op <= OP_SQ;
            r_dcnt <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_target <= s_axis_tdata;
                        r_r0 <= '0;
                        r_r1 <= R_INIT;
                        r_dr0 <= INT_W'($signed(s_axis_tdata));
                        r_step <= '0;
                        r_failed <= 1'b0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (mag <= (VAL_W+1)'(r_tol)) begin
                        r_state <= S_FIN;
                    end else if (r_step >= SW'(MAX_ITER)) begin
                        r_failed <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_ma <= INT_W'(r_r1);
                        r_mb <= INT_W'(r_r1);
                        r_op <= OP_SQ;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= mul_p;
                    r_state <= S_POST;
                end
                S_POST: begin
                    case (r_op)
                        OP_SQ: begin
                            r_sq <= post_a;
                            r_ma <= INT_W'(r_k4);
                            r_mb <= post_a;
                            r_op <= OP_K4;
                            r_state <= S_MUL;
                        end
                        OP_K4: begin
                            r_ma <= sat32(PROD_W'(post_a) + PROD_W'(r_k2));
                            r_mb <= r_sq;
                            r_op <= OP_K2;
                            r_state <= S_MUL;
                        end
                        OP_K2: begin
                            r_ma <= sat32(PROD_W'(post_a) + ONE_FX);
                            r_mb <= INT_W'(r_r1);
                            r_op <= OP_FWD;
                            r_state <= S_MUL;
                        end
                        OP_FWD: begin
                            r_dr1 <= sat32(PROD_W'(r_target) - PROD_W'(post_a));
                            r_state <= S_DEN;
                        end
                        default: begin
                            r_num <= pmag[NUM_W-1:0];
                            r_q_neg <= r_q_neg ^ r_prod[PROD_W-1];
                            r_rem <= '0;
                            r_dcnt <= '0;
                            r_state <= S_DIV;
                        end
                    endcase
                end
                S_DEN: begin
                    if (den == '0) begin
                        r_failed <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_dmag <= den[INT_W-1] ? INT_W'(-den) : INT_W'(den);
                        r_q_neg <= den[INT_W-1];
                        r_ma <= r_dr1;
                        r_mb <= INT_W'(diff);
                        r_op <= OP_COR;
                        r_state <= S_MUL;
                    end
                end
                S_DIV: begin
                    r_rem <= rem_ge ? INT_W'(rem_sh - {1'b0, r_dmag}) : rem_sh[INT_W-1:0];
                    r_num <= {r_num[NUM_W-2:0], rem_ge};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DW'(NUM_W - 1)) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_r0 <= r_r1;
                    if (nr > (NUM_W+2)'(VAL_MAX)) begin
                        r_r1 <= VAL_MAX;
                    end else if (nr < (NUM_W+2)'(VAL_MIN)) begin
                        r_r1 <= VAL_MIN;
                    end else begin
                        r_r1 <= nr[VAL_W-1:0];
                    end
                    r_dr0 <= r_dr1;
                    r_step <= r_step + 1'b1;
                    r_state <= S_CHECK;
                end
                S_FIN: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_r <= r_r1;
                        r_out_nc <= r_failed;
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_step_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= SW'(MAX_ITER))
        else $error("secant step count beyond cap");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dmag != '0))
        else $error("divider running with zero divisor");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_CHECK && !s_axis_tready))
        else $error("accepted request did not start the search");

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && m_axis_tvalid && !m_axis_tready) |=> (r_state == S_FIN))
        else $error("result overwrote an undelivered output");

endmodule

FILE: bench/radial_distortion_inverse_unit_tb.sv
// Self-checking bench for radial_distortion_inverse_unit: streams radii in, predicts each
// undistorted radius and convergence flag, and checks the results in order.
// Depends on rdi_pkg and the unit itself; stands alone otherwise.
`timescale 1ns / 100ps

module radial_distortion_inverse_unit_tb
    import rdi_pkg::*;
();

    localparam int STEP_CAP     = 16;
    localparam int FRAC         = 20;
    localparam int LATENCY_MAX  = 3 + 69 * STEP_CAP;
    localparam int IDLE_MAX     = 13;
    localparam int PHASE_ITEMS  = 105;
    localparam int RANDOM_PHASES = 9;
    localparam logic [CFG_W-1:0] CFG_UNUSED = 2'd3;
    localparam t_val ONE_Q20 = 24'sh100000;

    typedef struct packed {
        t_val radius_out;
        logic not_converged;
    } t_undistorted;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_W-1:0]   i_cfg_idx;
    logic [VAL_W-1:0]   i_cfg_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [VAL_W-1:0]   s_axis_tdata;   // [23:0] radius_in
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [VAL_W-1:0]   m_axis_tdata;   // [23:0] radius_out
    logic               m_axis_tuser;   // [0] not_converged

    longint             k2_coef = longint'(COEF_QUAD_RST);
    longint             k4_coef = longint'(COEF_QUAR_RST);
    longint             step_tolerance = longint'(TOL_RST);

    t_undistorted       expected_radii[$];
    int                 fault_count = 0;
    bit                 tx_idle = 1'b0;
    bit                 rx_idle = 1'b0;
    int                 rx_hold_cycles = 0;

    radial_distortion_inverse_unit #(
        .MAX_ITER  (STEP_CAP),
        .FRAC_BITS (FRAC)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint clip(longint x, longint lo, longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    function automatic longint sat32(longint x);
        return clip(x, -INT_LIM, INT_LIM);
    endfunction

    function automatic longint lens_forward(longint r);
        longint sq;
        longint acc;
        sq  = sat32((r * r) >>> FRAC);
        acc = sat32((k4_coef * sq) >>> FRAC);
        acc = sat32(acc + k2_coef);
        acc = sat32((acc * sq) >>> FRAC);
        acc = sat32(acc + (longint'(1) <<< FRAC));
        return sat32((acc * r) >>> FRAC);
    endfunction

    function automatic t_undistorted undistort(t_val radius);
        longint target;
        longint r0;
        longint r1;
        longint dr0;
        longint dr1;
        longint diff;
        longint mag;
        longint den;
        longint corr;
        int     step;
        bit     failed;
        bit     done;
        t_undistorted res;
        target = longint'(radius);
        r0     = 0;
        r1     = clip(longint'(1) <<< FRAC, VAL_MIN, VAL_MAX);
        dr0    = sat32(target - lens_forward(0));
        failed = 1'b0;
        done   = 1'b0;
        step   = 0;
        while (!done) begin
            diff = r1 - r0;
            mag  = (diff < 0) ? -diff : diff;
            if (mag <= step_tolerance) begin
                done = 1'b1;
            end else if (step >= STEP_CAP) begin
                failed = 1'b1;
                done   = 1'b1;
            end else begin
                dr1 = sat32(target - lens_forward(r1));
                den = sat32(dr1 - dr0);
                if (den == 0) begin
                    failed = 1'b1;
                    done   = 1'b1;
                end else begin
                    corr = (dr1 * diff) / den;
                    r0   = r1;
                    r1   = clip(r1 - corr, VAL_MIN, VAL_MAX);
                    dr0  = dr1;
                    step++;
                end
            end
        end
        res.radius_out    = t_val'(r1);
        res.not_converged = failed;
        return res;
    endfunction

    function automatic t_val draw_radius();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return t_val'(int'($urandom_range(0, 4194304)) - 2097152);
            4, 5:       return t_val'($urandom);
            6:          return t_val'(int'($urandom_range(0, 8192)) - 4096);
            7:          return t_val'(int'($urandom_range(0, 65536)) - 32768 + ONE_Q20);
            8: begin
                case ($urandom_range(0, 3))
                    0:       return VAL_MAX;
                    1:       return VAL_MIN;
                    2:       return '0;
                    default: return -ONE_Q20;
                endcase
            end
            default:    return t_val'($urandom);
        endcase
    endfunction

    function automatic t_val draw_coef();
        case ($urandom_range(0, 9))
            0, 1:    return t_val'($urandom);
            2:       return t_val'(int'($urandom_range(0, 8388607)) - 4194304);
            default: return t_val'(int'($urandom_range(0, 2097152)) - 1048576);
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] draw_tolerance_word();
        case ($urandom_range(0, 7))
            0:       return VAL_W'($urandom);
            1:       return VAL_W'($urandom_range(0, 16));
            default: return VAL_W'($urandom_range(0, 4096) | ({$urandom} & 32'h800000));
        endcase
    endfunction

    // Sender side: called and returning at a falling edge.
    task automatic send_radius(input t_val radius);
        int gap;
        gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= radius;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_radii.push_back(undistort(radius));
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_radii.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic apply_settings(input t_val quad, input t_val quar,
                                  input logic [VAL_W-1:0] tol_word);
        wait_for_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_QUAD;
        i_cfg_data <= quad;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_QUAR;
        i_cfg_data <= quar;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_TOL;
        i_cfg_data <= tol_word;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_UNUSED;
        i_cfg_data <= VAL_W'($urandom);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        k2_coef        = longint'(quad);
        k4_coef        = longint'(quar);
        step_tolerance = longint'(tol_word[TOL_W-1:0]);
        @(negedge i_clk);
    endtask

    task automatic test_default_settings();
        send_radius('0);
        send_radius(24'sd1);
        send_radius(-24'sd1);
        send_radius(ONE_Q20);
        send_radius(-ONE_Q20);
        send_radius(VAL_MAX);
        send_radius(VAL_MIN);
        send_radius(-24'sh2A0000);
    endtask

    task automatic test_identity_lens();
        apply_settings('0, '0, '0);
        send_radius(24'sh0C0000);
        send_radius(VAL_MIN);
        send_radius(VAL_MAX);
    endtask

    task automatic test_zero_denominator();
        // With k2 = -1.0 and k4 = 0 the model maps 1.0 to 0, so the first secant is flat.
        apply_settings(-ONE_Q20, '0, TOL_RST);
        send_radius('0);
        send_radius(24'sh040000);
        send_radius(VAL_MIN);
    endtask

    task automatic test_tolerance_extremes();
        apply_settings(COEF_QUAD_RST, COEF_QUAR_RST, 24'hFFFFFF);
        send_radius(24'sh123456);
        apply_settings(COEF_QUAD_RST, COEF_QUAR_RST, 24'h100000);
        send_radius(-24'sh054321);
        apply_settings(COEF_QUAD_RST, COEF_QUAR_RST, 24'h0FFFFF);
        send_radius(24'sh054321);
    endtask

    task automatic test_coefficient_extremes();
        apply_settings(VAL_MAX, VAL_MAX, '0);
        send_radius(24'sh200000);
        send_radius(VAL_MIN);
        send_radius(24'sd3);
        apply_settings(VAL_MIN, VAL_MIN, '0);
        send_radius(VAL_MAX);
        send_radius(-24'sh200000);
        send_radius('0);
    endtask

    task automatic test_output_backpressure();
        apply_settings(COEF_QUAD_RST, COEF_QUAR_RST, TOL_RST);
        tx_idle        = 1'b0;
        rx_idle        = 1'b0;
        rx_hold_cycles = 6000;
        repeat (6) send_radius(draw_radius());
        wait_for_results();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                apply_settings(COEF_QUAD_RST, COEF_QUAR_RST, TOL_RST);
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end else begin
                apply_settings(draw_coef(), draw_coef(), draw_tolerance_word());
                tx_idle = (phase == 1) ? 1'b1 : 1'($urandom_range(0, 3) != 0);
                rx_idle = (phase == 1) ? 1'b1 : 1'($urandom_range(0, 3) != 0);
            end
            repeat (PHASE_ITEMS) send_radius(draw_radius());
        end
        wait_for_results();
    endtask

    initial begin : rx_side
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(negedge i_clk);
                rx_hold_cycles = 0;
            end
            stall = rx_idle ? $urandom_range(0, IDLE_MAX) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    always @(posedge i_clk) begin : check_results
        t_undistorted want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_radii.size() == 0) begin
                $error("radius_out: expected nothing, got %0d", $signed(m_axis_tdata));
                fault_count++;
            end else begin
                want = expected_radii.pop_front();
                if (m_axis_tdata !== want.radius_out) begin
                    $error("radius_out: expected %0d, got %0d",
                           want.radius_out, $signed(m_axis_tdata));
                    fault_count++;
                end
                if (m_axis_tuser !== want.not_converged) begin
                    $error("not_converged: expected %0b, got %0b",
                           want.not_converged, m_axis_tuser);
                    fault_count++;
                end
            end
        end
    end

    initial begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_QUAD;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_settings();
        test_identity_lens();
        test_zero_denominator();
        test_tolerance_extremes();
        test_coefficient_extremes();
        test_output_backpressure();
        test_random_settings();

        wait_for_results();
        repeat (LATENCY_MAX + 100) @(negedge i_clk);
        if (fault_count == 0 && expected_radii.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/rdi_pkg.sv
hw/rtl/radial_distortion_inverse_unit.sv
bench/radial_distortion_inverse_unit_tb.sv
